FILE: src/pdsc_pkg.sv
// Package for the prime divisor subset check block.
// Holds the controller state type, the controller/datapath command and status structs and the default width.
`default_nettype none
package pdsc_pkg;
    localparam int unsigned VALUE_WIDTH_DEF = 63;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_GCD_START,
        S_GCD_WAIT,
        S_QUO_START,
        S_QUO_WAIT,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input operands
        logic gcd_init;   // x <= a, y <= b
        logic gcd_div;    // start remainder x % y
        logic gcd_step;   // x <= y, y <= remainder
        logic quo_div;    // start quotient b / x
        logic quo_step;   // a <= g, b <= quotient
        logic set_result; // latch answer
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic b_zero;
        logic a_zero;
        logic y_zero;
        logic g_one;
        logic div_busy;
    } t_stat;
endpackage
`default_nettype wire

FILE: src/prime_divisor_subset_check.sv
// Latency: data dependent. Each remainder or quotient step runs on the shared
// bit-serial divider (start, busy phase, update), and each outer pass reloads the
// gcd operands in S_CHECK.
// Throughput: one item at a time; next item accepted once the result is taken.
// Reset: synchronous active-low i_rst_n clears controller, divider and result state.
// Top level: joins pdsc_ctrl and pdsc_datapath; depends on pdsc_pkg.
`default_nettype none
module prime_divisor_subset_check
    import pdsc_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: base_value [W-1:0], test_value [2W-1:W], zero fill
    input  wire logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata: all_primes_divide [0], zero fill
    output logic [7:0]                  m_axis_tdata
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_res;

    pdsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pdsc_datapath #(.W(VALUE_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_base_value (s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_test_value (s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
        .o_stat       (w_stat),
        .o_result     (w_res)
    );

    assign m_axis_tdata = {7'b0, w_res};
endmodule
`default_nettype wire

FILE: src/pdsc_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses pdsc_pkg only for conventions; standalone arithmetic unit.
`default_nettype none
module pdsc_div
    import pdsc_pkg::*;
#(
    parameter int unsigned W = VALUE_WIDTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_busy,
    output logic [W-1:0]      o_quotient,
    output logic [W-1:0]      o_remainder
);
    localparam int unsigned CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [W-1:0]  r_q, n_q;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_d, n_d;
    logic [W:0]    w_shift;
    logic [W:0]    w_diff;

    // Shift in next dividend bit and trial subtract
    assign w_shift = {r_rem[W-1:0], r_q[W-1]};
    assign w_diff  = w_shift - {1'b0, r_d};

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        if (i_start) begin
            n_cnt  = CW'(W);
            n_busy = 1'b1;
            n_q    = i_dividend;
            n_rem  = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (w_diff[W]) begin
                n_rem = w_shift;
                n_q   = {r_q[W-2:0], 1'b0};
            end else begin
                n_rem = w_diff;
                n_q   = {r_q[W-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem[W-1:0];

`ifndef SYNTH
    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0)) else $error("busy with zero count");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy) else $error("divider not busy after start");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CW'(1) && !i_start) |=> !o_busy)
        else $error("divider overran");
`endif
endmodule
`default_nettype wire

FILE: src/pdsc_datapath.sv
// Datapath: operand registers, gcd registers and the shared divider.
// Depends on pdsc_pkg (t_cmd, t_stat) and pdsc_div.
`default_nettype none
module pdsc_datapath
    import pdsc_pkg::*;
#(
    parameter int unsigned W = VALUE_WIDTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_cmd         i_cmd,
    input  wire logic [W-1:0] i_base_value,
    input  wire logic [W-1:0] i_test_value,
    output t_stat             o_stat,
    output logic              o_result
);
    logic [W-1:0] r_a, r_b, r_x, r_y;
    logic         r_res;
    logic         w_start;
    logic [W-1:0] w_dividend, w_divisor, w_quo, w_rem;
    logic         w_busy;

    // Share one divider between remainder and quotient steps
    assign w_start    = i_cmd.gcd_div | i_cmd.quo_div;
    assign w_dividend = i_cmd.quo_div ? r_b : r_x;
    assign w_divisor  = i_cmd.quo_div ? r_x : r_y;

    pdsc_div #(.W(W)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_busy      (w_busy),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // Update operand and gcd registers on command
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_base_value;
            r_b <= i_test_value;
        end else if (i_cmd.quo_step) begin
            r_a <= r_x;
            r_b <= w_quo;
        end
        if (i_cmd.gcd_init) begin
            r_x <= r_a;
            r_y <= r_b;
        end else if (i_cmd.gcd_step) begin
            r_x <= r_y;
            r_y <= w_rem;
        end
    end

    // Latch the answer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= 1'b0;
        end else if (i_cmd.set_result) begin
            r_res <= (r_b == '0) ? (r_a == '0) : (r_b == W'(1));
        end
    end

    assign o_stat.b_zero   = (r_b == '0);
    assign o_stat.a_zero   = (r_a == '0);
    assign o_stat.y_zero   = (r_y == '0);
    assign o_stat.g_one    = (r_x == W'(1));
    assign o_stat.div_busy = w_busy;
    assign o_result        = r_res;
endmodule
`default_nettype wire

FILE: src/pdsc_ctrl.sv
// Controller FSM sequencing gcd and quotient steps and the stream handshake.
// Depends on pdsc_pkg (t_state, t_cmd, t_stat).
`default_nettype none
module pdsc_ctrl
    import pdsc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_stat i_stat,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    // Accept one item at a time; output register may still hold the last result
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (w_accept) n_state = S_CHECK;
            S_CHECK:     n_state = i_stat.b_zero ? S_DONE : S_GCD_START;
            S_GCD_START: n_state = i_stat.y_zero ? S_QUO_START : S_GCD_WAIT;
            S_GCD_WAIT: begin
                if (!i_stat.div_busy) n_state = S_GCD_START;
            end
            S_QUO_START: n_state = i_stat.g_one ? S_DONE : S_QUO_WAIT;
            // next gcd starts from (g, b/g), reloaded in S_CHECK
            S_QUO_WAIT: begin
                if (!i_stat.div_busy) n_state = S_CHECK;
            end
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE:      o_cmd.load = w_accept;
            S_CHECK:     o_cmd.gcd_init = 1'b1;
            S_GCD_START: begin
                if (!i_stat.y_zero) o_cmd.gcd_div = 1'b1;
            end
            S_GCD_WAIT:  o_cmd.gcd_step = !i_stat.div_busy;
            S_QUO_START: begin
                if (!i_stat.g_one) o_cmd.quo_div = 1'b1;
            end
            S_QUO_WAIT:  o_cmd.quo_step = !i_stat.div_busy;
            S_DONE: begin
                o_cmd.set_result = 1'b1;
                n_out_valid      = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.gcd_div, o_cmd.quo_div})) else $error("two divider starts");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready) else $error("ready while working");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_out_valid) else $error("result not presented");
`endif
endmodule
`default_nettype wire
